// ===== hw/rtl/rcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RMS current meter package
// Shared widths, register codes, configuration and control structures.
// ----------------------------------------------------------------------------
package rcm_pkg;

	// Field widths of the sample and result beats.
	localparam int ADC_W    = 10;
	localparam int CNT_W    = 16;
	localparam int MA_W     = 16;
	localparam int VREF_W   = 16;
	localparam int FS_W     = 16;
	localparam int SENS_W   = 10;

	// Internal datapath widths.
	localparam int SQ_W      = 2 * ADC_W;
	localparam int SUM_W     = 40;
	localparam int ROOT_W    = SUM_W / 2;
	localparam int MV_W      = ROOT_W + VREF_W;
	localparam int MA_SCALE  = 1000;
	localparam int MA_PROD_W = MV_W + 10;
	localparam int DIV_W     = 48;
	localparam int DEN_W     = 16;

	// Default values of the top-level parameters.
	localparam int ADC_BITS_DEFAULT    = 10;
	localparam int MAX_SAMPLES_DEFAULT = 16384;

	// Configuration port.
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_ZERO_OFFSET = 2'd0,
		REG_VREF_MV     = 2'd1,
		REG_FULL_SCALE  = 2'd2,
		REG_SENSITIVITY = 2'd3
	} reg_index_t;

	localparam logic [ADC_W-1:0]  ZERO_OFFSET_RESET = 10'd512;
	localparam logic [VREF_W-1:0] VREF_RESET        = 16'd5000;
	localparam logic [FS_W-1:0]   FULL_SCALE_RESET  = 16'd1023;
	localparam logic [SENS_W-1:0] SENSITIVITY_RESET = 10'd185;

	typedef struct packed {
		logic [ADC_W-1:0]  zero_offset;
		logic [VREF_W-1:0] vref_mv;
		logic [FS_W-1:0]   full_scale;
		logic [SENS_W-1:0] sensitivity;
	} cfg_t;

	// Operand selection of the shared divider.
	typedef enum logic [1:0] {
		DIV_MEAN = 2'd0,
		DIV_MV   = 2'd1,
		DIV_MA   = 2'd2
	} div_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     in_ready;
		logic     square_en;
		logic     acc_en;
		logic     div_start;
		div_sel_t div_sel;
		logic     sqrt_start;
		logic     mul_mv_en;
		logic     mul_ma_en;
		logic     out_wait;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_valid;
		logic last;
		logic div_done;
		logic sqrt_done;
		logic out_free;
	} status_t;

endpackage : rcm_pkg
`default_nettype wire

// ===== hw/rtl/rcm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RMS current meter channels
// Valid/ready channels for sample beats and result beats.
// ----------------------------------------------------------------------------

// Sample channel.
interface rcm_in_if;
	logic                       valid;
	logic                       ready;
	logic [rcm_pkg::ADC_W-1:0]  adc_sample;
	logic                       window_last;

	modport source (output valid, output adc_sample, output window_last, input ready);
	modport sink   (input valid, input adc_sample, input window_last, output ready);
endinterface : rcm_in_if

// Result channel.
interface rcm_out_if;
	logic                       valid;
	logic                       ready;
	logic [rcm_pkg::MA_W-1:0]   rms_milliamps;
	logic [rcm_pkg::ADC_W-1:0]  rms_adc_codes;
	logic [rcm_pkg::CNT_W-1:0]  samples_used;

	modport source (output valid, output rms_milliamps, output rms_adc_codes,
		output samples_used, input ready);
	modport sink   (input valid, input rms_milliamps, input rms_adc_codes,
		input samples_used, output ready);
endinterface : rcm_out_if
`default_nettype wire

// ===== hw/rtl/rcm_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RMS current meter registers
// APB-style register file holding zero point, reference and scale values.
// ----------------------------------------------------------------------------
module rcm_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [rcm_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [rcm_pkg::PDATA_W-1:0]   pwdata,
	output logic      [rcm_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready,
	output rcm_pkg::cfg_t                      cfg
);

	rcm_pkg::cfg_t       cfg_q;
	rcm_pkg::reg_index_t index;
	logic                wr_en;

	assign index  = rcm_pkg::reg_index_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_offset <= rcm_pkg::ZERO_OFFSET_RESET;
			cfg_q.vref_mv     <= rcm_pkg::VREF_RESET;
			cfg_q.full_scale  <= rcm_pkg::FULL_SCALE_RESET;
			cfg_q.sensitivity <= rcm_pkg::SENSITIVITY_RESET;
		end else if (wr_en) begin
			case (index)
				rcm_pkg::REG_ZERO_OFFSET: cfg_q.zero_offset <= pwdata[rcm_pkg::ADC_W-1:0];
				rcm_pkg::REG_VREF_MV:     cfg_q.vref_mv     <= pwdata[rcm_pkg::VREF_W-1:0];
				rcm_pkg::REG_FULL_SCALE:  cfg_q.full_scale  <= pwdata[rcm_pkg::FS_W-1:0];
				rcm_pkg::REG_SENSITIVITY: cfg_q.sensitivity <= pwdata[rcm_pkg::SENS_W-1:0];
				default: ;
			endcase
		end
	end

	// Read data, zero-extended.
	always_comb begin
		case (index)
			rcm_pkg::REG_ZERO_OFFSET: prdata = rcm_pkg::PDATA_W'(cfg_q.zero_offset);
			rcm_pkg::REG_VREF_MV:     prdata = rcm_pkg::PDATA_W'(cfg_q.vref_mv);
			rcm_pkg::REG_FULL_SCALE:  prdata = rcm_pkg::PDATA_W'(cfg_q.full_scale);
			rcm_pkg::REG_SENSITIVITY: prdata = rcm_pkg::PDATA_W'(cfg_q.sensitivity);
			default:                  prdata = '0;
		endcase
	end

endmodule : rcm_regs
`default_nettype wire

// ===== hw/rtl/rcm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RMS current meter divider
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module rcm_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [rcm_pkg::DIV_W-1:0]    dividend,
	input  wire logic [rcm_pkg::DEN_W-1:0]    divisor,
	output logic                              done,
	output logic      [rcm_pkg::DIV_W-1:0]    quotient
);

	localparam int DIV_W  = rcm_pkg::DIV_W;
	localparam int DEN_W  = rcm_pkg::DEN_W;
	localparam int CNT_B  = $clog2(DIV_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_B-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DIV_W-1:0] quo_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             ge;

	// One shift-and-subtract step.
	assign shifted  = {rem_q, quo_q[DIV_W-1]};
	assign ge       = shifted >= {1'b0, den_q};
	assign diff     = shifted - {1'b0, den_q};
	assign done     = done_q;
	assign quotient = quo_q;

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_B'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder and quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

endmodule : rcm_div
`default_nettype wire

// ===== hw/rtl/rcm_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RMS current meter square root
// Digit-by-digit floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module rcm_sqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [rcm_pkg::SUM_W-1:0]     radicand,
	output logic                               done,
	output logic      [rcm_pkg::ROOT_W-1:0]    root
);

	localparam int RAD_W  = rcm_pkg::SUM_W;
	localparam int ROOT_W = rcm_pkg::ROOT_W;
	localparam int REM_W  = ROOT_W + 4;
	localparam int CNT_B  = $clog2(ROOT_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_B-1:0]  cnt_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  shifted;
	logic [REM_W-1:0]  trial;
	logic              ge;

	// Bring down two radicand bits and try the next root bit.
	assign shifted = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign ge      = shifted >= trial;
	assign done    = done_q;
	assign root    = root_q;

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_B'(ROOT_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder, root and remaining radicand bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? (shifted - trial) : shifted;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

endmodule : rcm_sqrt
`default_nettype wire

// ===== hw/rtl/rcm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RMS current meter datapath
// Square accumulation, divider and root operands, scaling and result register.
// ----------------------------------------------------------------------------
module rcm_datapath #(
	parameter int ADC_BITS    = rcm_pkg::ADC_BITS_DEFAULT,
	parameter int MAX_SAMPLES = rcm_pkg::MAX_SAMPLES_DEFAULT
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  rcm_pkg::cfg_t   cfg,
	input  rcm_pkg::cmd_t   cmd,
	output rcm_pkg::status_t stat,
	rcm_in_if.sink       samples,
	rcm_out_if.source    results
);

	localparam int ADC_W    = rcm_pkg::ADC_W;
	localparam int SQ_W     = rcm_pkg::SQ_W;
	localparam int SUM_W    = rcm_pkg::SUM_W;
	localparam int CNT_W    = rcm_pkg::CNT_W;
	localparam int ROOT_W   = rcm_pkg::ROOT_W;
	localparam int MV_W     = rcm_pkg::MV_W;
	localparam int MAP_W    = rcm_pkg::MA_PROD_W;
	localparam int DIV_W    = rcm_pkg::DIV_W;
	localparam int DEN_W    = rcm_pkg::DEN_W;
	localparam int MA_W     = rcm_pkg::MA_W;

	// Only the low ADC_BITS bits of a code take part.
	localparam logic [ADC_W-1:0] CODE_MASK =
		(ADC_BITS >= ADC_W) ? {ADC_W{1'b1}} : ADC_W'((1 << ADC_BITS) - 1);
	localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(MAX_SAMPLES);

	logic [ADC_W-1:0]  sample_q;
	logic              last_q;
	logic [SQ_W-1:0]   sq_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  count_q;
	logic [DIV_W-1:0]  prod_q;
	logic              out_valid_q;
	logic [MA_W-1:0]   ma_q;
	logic [ADC_W-1:0]  codes_q;
	logic [CNT_W-1:0]  used_q;

	logic              accept;
	logic              out_free;
	logic              out_load;
	logic [ADC_W-1:0]  zero_m;
	logic [ADC_W-1:0]  dev;
	logic [SUM_W:0]    sum_next;
	logic [DIV_W-1:0]  dividend;
	logic [DEN_W-1:0]  divisor;
	logic [DEN_W-1:0]  fs_eff;
	logic [DEN_W-1:0]  sens_eff;
	logic              div_done;
	logic [DIV_W-1:0]  quotient;
	logic              sqrt_done;
	logic [ROOT_W-1:0] root;
	logic [MV_W-1:0]   mv_prod;
	logic [MAP_W-1:0]  ma_prod;

	// Handshake and status.
	assign accept          = cmd.in_ready && samples.valid;
	assign samples.ready   = cmd.in_ready;
	assign out_free        = !out_valid_q || results.ready;
	assign out_load        = cmd.out_wait && out_free;
	assign stat.in_valid   = samples.valid;
	assign stat.last       = last_q;
	assign stat.div_done   = div_done;
	assign stat.sqrt_done  = sqrt_done;
	assign stat.out_free   = out_free;

	// Absolute deviation from the zero point.
	assign zero_m = cfg.zero_offset & CODE_MASK;
	assign dev    = (sample_q >= zero_m) ? (sample_q - zero_m) : (zero_m - sample_q);

	// Saturating sum of squares.
	assign sum_next = {1'b0, sum_q} + (SUM_W + 1)'(sq_q);

	// Zero divisors count as one.
	assign fs_eff   = (cfg.full_scale != '0) ? cfg.full_scale : DEN_W'(1);
	assign sens_eff = (cfg.sensitivity != '0) ? DEN_W'(cfg.sensitivity) : DEN_W'(1);

	// Divider operand selection; an empty window gives a mean of zero.
	always_comb begin
		case (cmd.div_sel)
			rcm_pkg::DIV_MEAN: begin
				dividend = (count_q != '0) ? DIV_W'(sum_q) : '0;
				divisor  = (count_q != '0) ? count_q : DEN_W'(1);
			end
			rcm_pkg::DIV_MV: begin
				dividend = prod_q;
				divisor  = fs_eff;
			end
			rcm_pkg::DIV_MA: begin
				dividend = prod_q;
				divisor  = sens_eff;
			end
			default: begin
				dividend = prod_q;
				divisor  = DEN_W'(1);
			end
		endcase
	end

	// Scaling products.
	assign mv_prod = MV_W'(root) * MV_W'(cfg.vref_mv);
	assign ma_prod = MAP_W'(quotient[MV_W-1:0]) * MAP_W'(rcm_pkg::MA_SCALE);

	rcm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	rcm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (quotient[SUM_W-1:0]),
		.done     (sqrt_done),
		.root     (root)
	);

	// Accepted sample and its square.
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= samples.adc_sample & CODE_MASK;
			last_q   <= samples.window_last;
		end
		if (cmd.square_en) begin
			sq_q <= SQ_W'(dev) * SQ_W'(dev);
		end
		if (cmd.mul_mv_en) begin
			prod_q <= DIV_W'(mv_prod);
		end else if (cmd.mul_ma_en) begin
			prod_q <= DIV_W'(ma_prod);
		end
	end

	// Window accumulators, cleared when the result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (out_load) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (cmd.acc_en && (count_q < COUNT_LIMIT)) begin
			sum_q   <= sum_next[SUM_W] ? {SUM_W{1'b1}} : sum_next[SUM_W-1:0];
			count_q <= count_q + 1'b1;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload with saturation.
	always_ff @(posedge clk) begin
		if (out_load) begin
			ma_q    <= (|quotient[DIV_W-1:MA_W]) ? {MA_W{1'b1}} : quotient[MA_W-1:0];
			codes_q <= (|root[ROOT_W-1:ADC_W]) ? {ADC_W{1'b1}} : root[ADC_W-1:0];
			used_q  <= count_q;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.rms_milliamps = ma_q;
	assign results.rms_adc_codes = codes_q;
	assign results.samples_used  = used_q;

endmodule : rcm_datapath
`default_nettype wire

// ===== hw/rtl/rcm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RMS current meter controller
// Sequences accumulation and the window-end divide, root and scaling steps.
// ----------------------------------------------------------------------------
module rcm_ctrl (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  rcm_pkg::status_t stat,
	output rcm_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQUARE,
		S_ACC,
		S_MEAN,
		S_ROOT,
		S_MUL_MV,
		S_DIV_MV,
		S_MUL_MA,
		S_DIV_MA,
		S_OUT
	} state_t;

	// Commands after reset: ready for a sample, nothing else active.
	localparam rcm_pkg::cmd_t CMD_RESET = '{
		in_ready:   1'b1,
		square_en:  1'b0,
		acc_en:     1'b0,
		div_start:  1'b0,
		div_sel:    rcm_pkg::DIV_MEAN,
		sqrt_start: 1'b0,
		mul_mv_en:  1'b0,
		mul_ma_en:  1'b0,
		out_wait:   1'b0
	};

	state_t        state_q;
	state_t        state_n;
	rcm_pkg::cmd_t cmd_q;
	rcm_pkg::cmd_t cmd_n;

	assign cmd = cmd_q;

	// Next state and commands; one-cycle strobes drop unless renewed.
	always_comb begin
		state_n          = state_q;
		cmd_n            = cmd_q;
		cmd_n.square_en  = 1'b0;
		cmd_n.acc_en     = 1'b0;
		cmd_n.div_start  = 1'b0;
		cmd_n.sqrt_start = 1'b0;
		cmd_n.mul_mv_en  = 1'b0;
		cmd_n.mul_ma_en  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (stat.in_valid) begin
					cmd_n.in_ready  = 1'b0;
					cmd_n.square_en = 1'b1;
					state_n         = S_SQUARE;
				end
			end
			S_SQUARE: begin
				cmd_n.acc_en = 1'b1;
				state_n      = S_ACC;
			end
			S_ACC: begin
				if (stat.last) begin
					cmd_n.div_sel   = rcm_pkg::DIV_MEAN;
					cmd_n.div_start = 1'b1;
					state_n         = S_MEAN;
				end else begin
					cmd_n.in_ready = 1'b1;
					state_n        = S_IDLE;
				end
			end
			S_MEAN: begin
				if (stat.div_done) begin
					cmd_n.sqrt_start = 1'b1;
					state_n          = S_ROOT;
				end
			end
			S_ROOT: begin
				if (stat.sqrt_done) begin
					cmd_n.mul_mv_en = 1'b1;
					state_n         = S_MUL_MV;
				end
			end
			S_MUL_MV: begin
				cmd_n.div_sel   = rcm_pkg::DIV_MV;
				cmd_n.div_start = 1'b1;
				state_n         = S_DIV_MV;
			end
			S_DIV_MV: begin
				if (stat.div_done) begin
					cmd_n.mul_ma_en = 1'b1;
					state_n         = S_MUL_MA;
				end
			end
			S_MUL_MA: begin
				cmd_n.div_sel   = rcm_pkg::DIV_MA;
				cmd_n.div_start = 1'b1;
				state_n         = S_DIV_MA;
			end
			S_DIV_MA: begin
				if (stat.div_done) begin
					cmd_n.out_wait = 1'b1;
					state_n        = S_OUT;
				end
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd_n.out_wait = 1'b0;
					cmd_n.in_ready = 1'b1;
					state_n        = S_IDLE;
				end
			end
			default: begin
				cmd_n.in_ready = 1'b1;
				cmd_n.out_wait = 1'b0;
				state_n        = S_IDLE;
			end
		endcase
	end

	// State and registered commands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= CMD_RESET;
		end else begin
			state_q <= state_n;
			cmd_q   <= cmd_n;
		end
	end

endmodule : rcm_ctrl
`default_nettype wire

// ===== hw/rtl/rms_current_meter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RMS current meter
// True-RMS current from ADC samples with integer mean, root and scaling.
//
//   Channel   Direction  Handshake          Beat contents
//   samples   in         valid/ready        adc_sample, window_last
//   results   out        valid/ready        rms_milliamps, rms_adc_codes,
//                                           samples_used
//   APB       in/out     psel/penable       four configuration registers
//
// A sample that does not end its window goes through accept, square and
// accumulate steps. A window-end sample adds three passes through the
// shared 48-step bit-serial divider and a 20-step root.
// Reset clears the window sum and count and loads the register defaults.
// A result waits in the output register while samples are accepted again;
// the next window end stalls only if that result is still not taken.
// ----------------------------------------------------------------------------
module rms_current_meter_top #(
	parameter int ADC_BITS    = rcm_pkg::ADC_BITS_DEFAULT,
	parameter int MAX_SAMPLES = rcm_pkg::MAX_SAMPLES_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [rcm_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [rcm_pkg::PDATA_W-1:0]   pwdata,
	output logic      [rcm_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready,
	rcm_in_if.sink                             samples,
	rcm_out_if.source                          results
);

	rcm_pkg::cfg_t    cfg;
	rcm_pkg::cmd_t    cmd;
	rcm_pkg::status_t stat;

	// Configuration registers.
	rcm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer.
	rcm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Arithmetic and result register.
	rcm_datapath #(
		.ADC_BITS    (ADC_BITS),
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cmd     (cmd),
		.stat    (stat),
		.samples (samples),
		.results (results)
	);

endmodule : rms_current_meter_top
`default_nettype wire

// ===== verif/tb_rms_current_meter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RMS current meter testbench
// Streams ADC sample beats into the meter and checks every result beat against
// a behavioral model of the RMS, millivolt and milliamp math kept in this file.
// It covers register extremes, zero divisors, the sample count limit and an
// output back-pressure stretch that stalls the sample input.
// ----------------------------------------------------------------------------
module tb_rms_current_meter_top;

	localparam int ADC_W         = rcm_pkg::ADC_W;
	localparam int MA_W          = rcm_pkg::MA_W;
	localparam int CNT_W         = rcm_pkg::CNT_W;
	localparam int SUM_W         = rcm_pkg::SUM_W;
	localparam int VREF_W        = rcm_pkg::VREF_W;
	localparam int FS_W          = rcm_pkg::FS_W;
	localparam int SENS_W        = rcm_pkg::SENS_W;
	localparam int PADDR_W       = rcm_pkg::PADDR_W;
	localparam int PDATA_W       = rcm_pkg::PDATA_W;
	localparam int MAX_WINDOW    = rcm_pkg::MAX_SAMPLES_DEFAULT;
	localparam int SETTLE_CYCLES = 250;
	localparam int HOLD_CYCLES   = 2000;
	localparam int RANDOM_BEATS  = 600;
	localparam int TIMEOUT_NS    = 250_000_000;

	typedef struct packed {
		logic [ADC_W-1:0] adc;
		logic             last;
	} sample_beat_t;

	typedef struct packed {
		logic [MA_W-1:0]  milliamps;
		logic [ADC_W-1:0] codes;
		logic [CNT_W-1:0] used;
	} rms_result_t;

	// Clock, reset and configuration port.
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// Local copies of the channel inputs, driven at the clock edge.
	logic             in_valid = 1'b0;
	logic [ADC_W-1:0] in_adc = '0;
	logic             in_last = 1'b0;
	logic             out_ready = 1'b0;

	rcm_in_if  samples_ch ();
	rcm_out_if results_ch ();

	assign samples_ch.valid       = in_valid;
	assign samples_ch.adc_sample  = in_adc;
	assign samples_ch.window_last = in_last;
	assign results_ch.ready       = out_ready;

	rms_current_meter_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.samples (samples_ch),
		.results (results_ch)
	);

	// Register shadow and window accumulator of the model.
	logic [ADC_W-1:0]  cfg_zero = rcm_pkg::ZERO_OFFSET_RESET;
	logic [VREF_W-1:0] cfg_vref = rcm_pkg::VREF_RESET;
	logic [FS_W-1:0]   cfg_fs   = rcm_pkg::FULL_SCALE_RESET;
	logic [SENS_W-1:0] cfg_sens = rcm_pkg::SENSITIVITY_RESET;
	logic [SUM_W-1:0]  window_square_sum = '0;
	logic [CNT_W-1:0]  window_count = '0;

	sample_beat_t pending_samples[$];
	rms_result_t  expected_rms[$];
	int           beats_queued = 0;
	int           beats_accepted = 0;
	int           mismatches = 0;
	logic         idle_on = 1'b1;
	logic         rx_hold = 1'b0;
	logic         pressure_req = 1'b0;
	int           sender_gap = 0;
	int           receiver_stall = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	// Floor square root: build the result one bit at a time from the top.
	function automatic logic [63:0] floor_root(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] trial;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = r | (64'd1 << b);
			if (trial * trial <= v)
				r = trial;
		end
		return r;
	endfunction

	// Accumulate one accepted sample; a window end queues its expected result.
	task automatic accumulate_sample(sample_beat_t s);
		logic [63:0] dev, total, mean, root, mv, ma, fs, sens;
		rms_result_t r;
		if (window_count < MAX_WINDOW) begin
			dev = (s.adc >= cfg_zero) ? 64'(s.adc) - 64'(cfg_zero) : 64'(cfg_zero) - 64'(s.adc);
			total = 64'(window_square_sum) + dev * dev;
			window_square_sum = (total > 64'hFF_FFFF_FFFF) ? '1 : total[SUM_W-1:0];
			window_count = window_count + 1'b1;
		end
		if (s.last) begin
			mean = (window_count != 0) ? 64'(window_square_sum) / 64'(window_count) : 64'd0;
			root = floor_root(mean);
			fs = (cfg_fs != 0) ? 64'(cfg_fs) : 64'd1;
			sens = (cfg_sens != 0) ? 64'(cfg_sens) : 64'd1;
			mv = root * 64'(cfg_vref) / fs;
			ma = mv * rcm_pkg::MA_SCALE / sens;
			r.milliamps = (ma > 64'hFFFF) ? '1 : ma[MA_W-1:0];
			r.codes = (root > 64'd1023) ? '1 : root[ADC_W-1:0];
			r.used = window_count;
			expected_rms.push_back(r);
			window_square_sum = '0;
			window_count = '0;
		end
	endtask

	// Sample driver: holds a beat until taken, with random idle bursts.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !samples_ch.ready)) begin
			if (in_valid) begin
				accumulate_sample(pending_samples.pop_front());
				beats_accepted++;
			end
			if (sender_gap > 0) begin
				sender_gap--;
				in_valid <= 1'b0;
			end else if (pending_samples.size() == 0) begin
				in_valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				sender_gap = $urandom_range(1, 18) - 1;
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				in_adc <= pending_samples[0].adc;
				in_last <= pending_samples[0].last;
			end
		end
	end

	// Result monitor: compares each taken beat with the oldest expectation.
	always @(posedge clk) begin
		rms_result_t want;
		if (arst_n && results_ch.valid && out_ready) begin
			if (expected_rms.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result ma=%0d codes=%0d used=%0d", $realtime,
						results_ch.rms_milliamps, results_ch.rms_adc_codes,
						results_ch.samples_used);
			end else begin
				want = expected_rms.pop_front();
				if (results_ch.rms_milliamps !== want.milliamps ||
						results_ch.rms_adc_codes !== want.codes ||
						results_ch.samples_used !== want.used) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: expected ma=%0d codes=%0d used=%0d, got ma=%0d codes=%0d used=%0d",
							$realtime, want.milliamps, want.codes, want.used,
							results_ch.rms_milliamps, results_ch.rms_adc_codes,
							results_ch.samples_used);
				end
			end
		end
		if (!arst_n || rx_hold) begin
			out_ready <= 1'b0;
		end else if (receiver_stall > 0) begin
			receiver_stall--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			receiver_stall = $urandom_range(1, 18) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Long receiver hold-off so that results back up into the sample input.
	initial begin
		wait (pressure_req);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Hard limit on the run.
	initial begin
		#(TIMEOUT_NS);
		$display("== FAIL ==");
		$finish;
	end

	task automatic queue_beat(int adc, bit last);
		sample_beat_t s;
		s.adc = adc[ADC_W-1:0];
		s.last = last;
		pending_samples.push_back(s);
		beats_queued++;
	endtask

	// One window of samples, mostly a waveform around the zero point.
	task automatic queue_window(int len);
		int amp, v;
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 9) < 7) begin
				amp = $urandom_range(0, 511);
				v = int'(cfg_zero) + int'($urandom_range(0, 2 * amp)) - amp;
				v = (v < 0) ? 0 : (v > 1023) ? 1023 : v;
			end else begin
				v = $urandom_range(0, 1023);
			end
			queue_beat(v, k == len - 1);
		end
	endtask

	// Waits until every beat is taken and every result has come back.
	task automatic drain_and_settle();
		while (beats_accepted != beats_queued || expected_rms.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write with a setup and an access phase; the shadow copy follows the register.
	task automatic write_register(rcm_pkg::reg_index_t idx, logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			rcm_pkg::REG_ZERO_OFFSET: cfg_zero = value[ADC_W-1:0];
			rcm_pkg::REG_VREF_MV:     cfg_vref = value[VREF_W-1:0];
			rcm_pkg::REG_FULL_SCALE:  cfg_fs = value[FS_W-1:0];
			rcm_pkg::REG_SENSITIVITY: cfg_sens = value[SENS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(int zero, int vref, int fs, int sens);
		write_register(rcm_pkg::REG_ZERO_OFFSET, zero);
		write_register(rcm_pkg::REG_VREF_MV, vref);
		write_register(rcm_pkg::REG_FULL_SCALE, fs);
		write_register(rcm_pkg::REG_SENSITIVITY, sens);
	endtask

	// Stimulus sequence.
	initial begin
		int random_beats;
		int phase;
		int len;
		random_beats = 0;
		phase = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults: centered, rail and mixed windows.
		queue_beat(512, 1);
		queue_beat(0, 1);
		queue_beat(1023, 1);
		queue_beat(0, 0);
		queue_beat(1023, 0);
		queue_beat(1, 0);
		queue_beat(1022, 1);
		queue_beat(511, 0);
		queue_beat(513, 1);
		drain_and_settle();

		// Largest scale: the milliamp value saturates.
		write_all(0, 16'hFFFF, 1, 1);
		queue_beat(1023, 1);
		queue_beat(1, 1);
		queue_beat(0, 1);
		drain_and_settle();

		// Zero divisors count as one; zero point at the top code.
		write_all(1023, 16'hFFFF, 0, 0);
		queue_beat(0, 1);
		queue_beat(1022, 0);
		queue_beat(1023, 1);
		drain_and_settle();

		// Smallest scale and the largest sensitivity code.
		write_all(300, 1, 16'hFFFF, 1023);
		queue_beat(1023, 1);
		queue_beat(0, 1);
		drain_and_settle();

		// A window past the sample count limit, sent without gaps.
		write_all(rcm_pkg::ZERO_OFFSET_RESET, rcm_pkg::VREF_RESET,
			rcm_pkg::FULL_SCALE_RESET, rcm_pkg::SENSITIVITY_RESET);
		idle_on = 1'b0;
		for (int i = 0; i < MAX_WINDOW + 6; i++)
			queue_beat($urandom_range(0, 1023), i == MAX_WINDOW + 5);
		drain_and_settle();

		// Short windows against a stalled receiver.
		pressure_req = 1'b1;
		for (int i = 0; i < 40; i++)
			queue_window($urandom_range(1, 3));
		drain_and_settle();

		// Random registers and windows; the third phase and the final stretch run without gaps.
		while (random_beats < RANDOM_BEATS) begin
			idle_on = (phase < 5) && (phase != 2);
			write_all(($urandom_range(0, 3) == 0) ? 1023 * $urandom_range(0, 1)
					: $urandom_range(0, 1023),
				($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(1, 65535),
				($urandom_range(0, 1) == 0) ? $urandom_range(1, 4095)
					: $urandom_range(1, 65535),
				$urandom_range(1, 1000));
			for (int n = 0; n < 100; n += len) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
					: $urandom_range(1, 12);
				queue_window(len);
			end
			random_beats = beats_queued - beats_accepted + random_beats;
			drain_and_settle();
			phase++;
		end

		if (mismatches == 0 && expected_rms.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule : tb_rms_current_meter_top
